// ===== sv/lzfd_pkg.sv =====
// Package for the LZ77 flag-word decompressor.
// Holds command codes, parse phases, status codes and sizes; no dependencies.
`timescale 1ns / 1ps
package lzfd_pkg;
    localparam int WINDOW_SIZE = 8192;
    localparam int WIN_AW = $clog2(WINDOW_SIZE);
    localparam int MAX_BLOCK = 262144;
    localparam int CNT_W = 19;

    typedef enum logic [1:0] {
        t_CMD_BYTE = 2'd0,
        t_CMD_TICK = 2'd1,
        t_CMD_END  = 2'd2,
        t_CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        t_ST_OK      = 2'd0,
        t_ST_OFFSET  = 2'd1,
        t_ST_SHORT   = 2'd2,
        t_ST_REFUSED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        t_PH_FLAG0   = 4'd0,
        t_PH_FLAG1   = 4'd1,
        t_PH_FLAG2   = 4'd2,
        t_PH_FLAG3   = 4'd3,
        t_PH_TOKEN   = 4'd4,
        t_PH_INFO_HI = 4'd5,
        t_PH_EXTRA   = 4'd6,
        t_PH_E16_0   = 4'd7,
        t_PH_E16_1   = 4'd8,
        t_PH_E32_0   = 4'd9,
        t_PH_E32_1   = 4'd10,
        t_PH_E32_2   = 4'd11,
        t_PH_E32_3   = 4'd12,
        t_PH_BAD13   = 4'd13,
        t_PH_BAD14   = 4'd14,
        t_PH_BAD15   = 4'd15
    } t_phase;

    localparam logic [0:0] REG_MAX_OUTPUT = 1'b0;
endpackage

// ===== sv/lz77_flag_word_decompressor_core.sv =====
// Top level of the LZ77 flag-word decompressor: parser, copy engine, history RAM.
// Depends on lzfd_pkg.
//
// channel | dir | beat
// s_axis  | in  | tdata[7:0]=data_byte, tuser[1:0]=command
// m_axis  | out | tdata[7:0]=out_byte, [8]=copy_pending, [10:9]=status,
//         |     |   [29:11]=out_count; tlast=block_done; tuser[0]=byte_valid
// apb     | in  | max_output at address 0
//
// One beat a cycle, literals and copy ticks alike, unless the output stalls; a tick
// reads the 8192-byte history RAM ahead (read address follows next-state).
// Back-to-back copies with distance 1 are served from the write-forward path.
// Reset is synchronous; history is not cleared. One output register:
// input is taken whenever the output register is empty or being drained.
`timescale 1ns / 1ps
module lz77_flag_word_decompressor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_byte[7:0], copy_pending, status[1:0],
                                       // out_count[18:0], zero pad[1:0]
    output logic        m_axis_tlast,  // block_done
    output logic [0:0]  m_axis_tuser,  // byte_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = lzfd_pkg::WIN_AW;
    localparam int CW = lzfd_pkg::CNT_W;

    logic [CW-1:0] r_max, r_produced, n_produced;
    logic [31:0]   r_flag, n_flag, r_tok, n_tok, r_rem, n_rem;
    logic [5:0]    r_tidx, n_tidx;
    lzfd_pkg::t_phase r_ph, n_ph;
    logic [15:0]   r_info, n_info;
    logic [AW:0]   r_dist, n_dist;
    logic [2:0]    r_seen, n_seen;
    logic          r_err, n_err;

    logic [7:0] mem [0:lzfd_pkg::WINDOW_SIZE-1];
    logic [7:0] r_rd;
    logic       r_fwd;
    logic [7:0] r_last;

    logic          r_ov;
    logic [31:0]   r_od;
    logic          r_ol;
    logic [0:0]    r_ou;
    logic          acc, wr_en;
    logic [7:0]    wr_data, res_b, hist_b;
    logic          res_v, res_done;
    logic [1:0]    res_st;
    logic [CW-1:0] res_cnt, limit;
    logic [AW-1:0] rd_addr;
    lzfd_pkg::t_cmd cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == lzfd_pkg::REG_MAX_OUTPUT) ? {13'd0, r_max} : 32'd0;
    assign s_axis_tready = !r_ov || m_axis_tready;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign cmd = lzfd_pkg::t_cmd'(s_axis_tuser);
    assign limit = (r_max < CW'(lzfd_pkg::MAX_BLOCK)) ? r_max : CW'(lzfd_pkg::MAX_BLOCK);
    assign hist_b = r_fwd ? r_last : r_rd;

    always_comb begin
        logic [CW-1:0] off;
        logic          fin;
        logic [31:0]   flen;
        logic [31:0]   rem0;
        n_produced = r_produced; n_flag = r_flag; n_tok = r_tok; n_rem = r_rem;
        n_tidx = r_tidx; n_ph = r_ph; n_info = r_info; n_dist = r_dist;
        n_seen = r_seen; n_err = r_err;
        res_v = 1'b0; res_b = 8'd0; res_done = 1'b0; res_st = lzfd_pkg::t_ST_OK;
        res_cnt = '0; wr_en = 1'b0; wr_data = 8'd0;
        fin = 1'b0; flen = 32'd0; off = '0;
        rem0 = (r_rem != 32'd0 && r_produced >= limit) ? 32'd0 : r_rem;
        if (acc) begin
            n_rem = rem0;
            if (r_err) begin
                res_st = lzfd_pkg::t_ST_OFFSET;
            end else if (rem0 != 32'd0 && (cmd == lzfd_pkg::t_CMD_BYTE ||
                                           cmd == lzfd_pkg::t_CMD_END)) begin
                res_st = lzfd_pkg::t_ST_REFUSED;
            end else if (cmd == lzfd_pkg::t_CMD_BYTE) begin
                if (r_seen < 3'd4) n_seen = r_seen + 3'd1;
                if (r_produced < limit) begin
                    unique case (r_ph)
                        lzfd_pkg::t_PH_FLAG0, lzfd_pkg::t_PH_FLAG1,
                        lzfd_pkg::t_PH_FLAG2, lzfd_pkg::t_PH_FLAG3: begin
                            n_flag = r_flag | ({24'd0, s_axis_tdata} << {r_ph[1:0], 3'd0});
                            n_ph = lzfd_pkg::t_phase'(r_ph + 4'd1);
                            if (r_ph == lzfd_pkg::t_PH_FLAG3) n_tidx = 6'd0;
                        end
                        lzfd_pkg::t_PH_TOKEN: begin
                            if (!r_flag[r_tidx[4:0]]) begin
                                res_v = 1'b1; res_b = s_axis_tdata;
                                wr_en = 1'b1; wr_data = s_axis_tdata;
                                n_produced = r_produced + CW'(1);
                                n_tidx = r_tidx + 6'd1;
                                n_ph = (r_tidx >= 6'd31) ? lzfd_pkg::t_PH_FLAG0
                                                         : lzfd_pkg::t_PH_TOKEN;
                                n_tok = 32'd0;
                            end else begin
                                n_info = {8'd0, s_axis_tdata};
                                n_ph = lzfd_pkg::t_PH_INFO_HI;
                            end
                        end
                        lzfd_pkg::t_PH_INFO_HI: begin
                            n_info = {s_axis_tdata, r_info[7:0]};
                            if (r_info[2:0] == 3'd7) n_ph = lzfd_pkg::t_PH_EXTRA;
                            else begin fin = 1'b1; flen = {29'd0, r_info[2:0]} + 32'd3; end
                        end
                        lzfd_pkg::t_PH_EXTRA: begin
                            if (s_axis_tdata == 8'hFF) begin
                                n_tok = 32'd0; n_ph = lzfd_pkg::t_PH_E16_0;
                            end else begin
                                fin = 1'b1; flen = {24'd0, s_axis_tdata} + 32'd10;
                            end
                        end
                        lzfd_pkg::t_PH_E16_0: begin
                            n_tok = {24'd0, s_axis_tdata}; n_ph = lzfd_pkg::t_PH_E16_1;
                        end
                        lzfd_pkg::t_PH_E16_1: begin
                            n_tok = r_tok | {16'd0, s_axis_tdata, 8'd0};
                            if (n_tok != 32'd0) begin fin = 1'b1; flen = n_tok; end
                            else n_ph = lzfd_pkg::t_PH_E32_0;
                        end
                        lzfd_pkg::t_PH_E32_0, lzfd_pkg::t_PH_E32_1,
                        lzfd_pkg::t_PH_E32_2, lzfd_pkg::t_PH_E32_3: begin
                            n_tok = r_tok | ({24'd0, s_axis_tdata} << {r_ph[1:0] - 2'd1, 3'd0});
                            if (r_ph == lzfd_pkg::t_PH_E32_3) begin
                                fin = 1'b1; flen = n_tok;
                            end else n_ph = lzfd_pkg::t_phase'(r_ph + 4'd1);
                        end
                        default: n_ph = lzfd_pkg::t_PH_FLAG0;
                    endcase
                    if (fin) begin
                        off = CW'(n_info[15:3]) + CW'(1);
                        if (off > r_produced) begin
                            n_err = 1'b1; n_rem = 32'd0;
                        end else begin
                            n_dist = off[AW:0]; n_rem = flen;
                            n_tidx = r_tidx + 6'd1;
                            n_ph = (r_tidx >= 6'd31) ? lzfd_pkg::t_PH_FLAG0
                                                     : lzfd_pkg::t_PH_TOKEN;
                            n_tok = 32'd0;
                        end
                    end
                    if (n_ph == lzfd_pkg::t_PH_FLAG0) n_flag = 32'd0;
                end
                if (n_err) res_st = lzfd_pkg::t_ST_OFFSET;
            end else if (cmd == lzfd_pkg::t_CMD_TICK) begin
                if (rem0 != 32'd0) begin
                    res_v = 1'b1; res_b = hist_b;
                    wr_en = 1'b1; wr_data = hist_b;
                    n_produced = r_produced + CW'(1);
                    n_rem = (n_produced >= limit) ? 32'd0 : rem0 - 32'd1;
                end
            end
            res_cnt = n_produced;
            if (cmd == lzfd_pkg::t_CMD_END && (r_err || rem0 == 32'd0)) begin
                res_done = 1'b1;
                if (r_err) res_cnt = '0;
                else if (r_seen < 3'd4) begin
                    res_st = lzfd_pkg::t_ST_SHORT; res_cnt = '0;
                end
                n_produced = '0; n_flag = 32'd0; n_tidx = 6'd32;
                n_ph = lzfd_pkg::t_PH_FLAG0; n_tok = 32'd0; n_info = 16'd0;
                n_rem = 32'd0; n_dist = '0; n_seen = 3'd0; n_err = 1'b0;
            end
        end
        rd_addr = n_produced[AW-1:0] - n_dist[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_produced[AW-1:0]] <= wr_data;
        r_rd   <= mem[rd_addr];
        r_fwd  <= wr_en && (rd_addr == r_produced[AW-1:0]);
        if (wr_en) r_last <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= CW'(lzfd_pkg::MAX_BLOCK);
            r_produced <= '0; r_flag <= 32'd0; r_tok <= 32'd0; r_rem <= 32'd0;
            r_tidx <= 6'd32; r_ph <= lzfd_pkg::t_PH_FLAG0; r_info <= 16'd0;
            r_dist <= '0; r_seen <= 3'd0; r_err <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == lzfd_pkg::REG_MAX_OUTPUT)
                r_max <= pwdata[CW-1:0];
            r_produced <= n_produced; r_flag <= n_flag; r_tok <= n_tok;
            r_rem <= n_rem; r_tidx <= n_tidx; r_ph <= n_ph; r_info <= n_info;
            r_dist <= n_dist; r_seen <= n_seen; r_err <= n_err;
            if (acc) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_od <= {2'd0, res_cnt, res_st,
                     (n_rem != 32'd0 && !n_err && !res_done), res_b};
            r_ol <= res_done;
            r_ou <= res_v;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tlast  = r_ol;
    assign m_axis_tuser  = r_ou;

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov |-> s_axis_tready) else $error("input stalled with empty output");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_ov) else $error("accepted beat lost");
    a_errrem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_rem == 32'd0) else $error("copy pending after error");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && res_done) |=> r_produced == '0) else $error("end did not clear");
endmodule

// ===== dv/lz77_flag_word_decompressor_core_test.sv =====
// Self-checking test of the LZ77 flag-word decompressor core.
// Streams compressed bytes, copy ticks and end beats and checks every output beat
// against a behavioral predictor; depends on lzfd_pkg and the core.
`timescale 1ns / 1ps
module lz77_flag_word_decompressor_core_test;

    typedef struct packed {
        logic [18:0]       count;
        lzfd_pkg::t_status status;
        logic              done;
        logic              pending;
        logic              valid;
        logic [7:0]        data;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lz77_flag_word_decompressor_core dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  hist [0:lzfd_pkg::WINDOW_SIZE-1];
    logic [31:0] produced, flags, tok_idx, tok_bytes, info, remaining, distance, seen, cap;
    logic [3:0]  phase;
    logic        err;
    t_beat       pending_beats[$];
    int          failures = 0;
    int          stall_pct = 28;
    int          sent = 0;

    function automatic logic [31:0] limit_now();
        return (cap < lzfd_pkg::MAX_BLOCK) ? cap : lzfd_pkg::MAX_BLOCK;
    endfunction

    task automatic clear_block();
        produced = 0; flags = 0; tok_idx = 32; phase = lzfd_pkg::t_PH_FLAG0; tok_bytes = 0;
        info = 0; remaining = 0; distance = 0; seen = 0; err = 1'b0;
    endtask

    task automatic token_done();
        tok_idx++;
        phase = (tok_idx >= 32) ? lzfd_pkg::t_PH_FLAG0 : lzfd_pkg::t_PH_TOKEN;
        tok_bytes = 0;
    endtask

    task automatic finish_match(input logic [31:0] len);
        logic [31:0] off;
        off = (info >> 3) + 1;
        if (off > produced) begin
            err = 1'b1;
            remaining = 0;
        end else begin
            distance = off;
            remaining = len;
            token_done();
        end
    endtask

    task automatic emit(input logic [7:0] b, inout t_beat r);
        hist[produced[12:0]] = b;
        produced++;
        r.valid = 1'b1;
        r.data = b;
    endtask

    task automatic parse_byte(input logic [7:0] b, inout t_beat r);
        if (seen < 4) seen++;
        if (produced >= limit_now()) return;
        if (phase < lzfd_pkg::t_PH_TOKEN) begin
            flags |= 32'(b) << (8 * phase);
            phase++;
            if (phase == lzfd_pkg::t_PH_TOKEN) tok_idx = 0;
            return;
        end
        case (phase)
            lzfd_pkg::t_PH_TOKEN: begin
                if (!flags[tok_idx[4:0]]) begin
                    emit(b, r);
                    token_done();
                end else begin
                    info = b;
                    phase = lzfd_pkg::t_PH_INFO_HI;
                end
            end
            lzfd_pkg::t_PH_INFO_HI: begin
                info = (info | (32'(b) << 8)) & 32'hFFFF;
                if (info[2:0] == 3'd7) phase = lzfd_pkg::t_PH_EXTRA;
                else finish_match(info[2:0] + 3);
            end
            lzfd_pkg::t_PH_EXTRA: begin
                if (b == 8'hFF) begin
                    tok_bytes = 0;
                    phase = lzfd_pkg::t_PH_E16_0;
                end else begin
                    finish_match(b + 10);
                end
            end
            lzfd_pkg::t_PH_E16_0: begin
                tok_bytes = b;
                phase = lzfd_pkg::t_PH_E16_1;
            end
            lzfd_pkg::t_PH_E16_1: begin
                tok_bytes |= 32'(b) << 8;
                if (tok_bytes != 0) finish_match(tok_bytes);
                else phase = lzfd_pkg::t_PH_E32_0;
            end
            lzfd_pkg::t_PH_E32_0, lzfd_pkg::t_PH_E32_1,
            lzfd_pkg::t_PH_E32_2, lzfd_pkg::t_PH_E32_3: begin
                tok_bytes |= 32'(b) << (8 * (phase - lzfd_pkg::t_PH_E32_0));
                if (phase == lzfd_pkg::t_PH_E32_3) finish_match(tok_bytes);
                else phase++;
            end
            default: phase = lzfd_pkg::t_PH_FLAG0;
        endcase
        if (phase == lzfd_pkg::t_PH_FLAG0) flags = 0;
    endtask

    task automatic predict(input lzfd_pkg::t_cmd cmd, input logic [7:0] b);
        t_beat r;
        logic [31:0] cnt;
        r = '0;
        r.status = lzfd_pkg::t_ST_OK;
        if (remaining != 0 && produced >= limit_now()) remaining = 0;
        if (err) begin
            r.status = lzfd_pkg::t_ST_OFFSET;
            if (cmd == lzfd_pkg::t_CMD_END) begin
                r.done = 1'b1;
                pending_beats.push_back(r);
                clear_block();
                return;
            end
        end else if (remaining != 0 && (cmd == lzfd_pkg::t_CMD_BYTE ||
                                        cmd == lzfd_pkg::t_CMD_END)) begin
            r.status = lzfd_pkg::t_ST_REFUSED;
        end else if (cmd == lzfd_pkg::t_CMD_BYTE) begin
            parse_byte(b, r);
            if (err) r.status = lzfd_pkg::t_ST_OFFSET;
        end else if (cmd == lzfd_pkg::t_CMD_TICK) begin
            if (remaining != 0) begin
                emit(hist[13'(produced - distance)], r);
                remaining--;
                if (produced >= limit_now()) remaining = 0;
            end
        end else if (cmd == lzfd_pkg::t_CMD_END) begin
            cnt = produced;
            if (seen < 4) begin
                r.status = lzfd_pkg::t_ST_SHORT;
                cnt = 0;
            end
            r.done = 1'b1;
            r.count = cnt[18:0];
            pending_beats.push_back(r);
            clear_block();
            return;
        end
        r.pending = (remaining != 0) && !err;
        r.count = produced[18:0];
        pending_beats.push_back(r);
    endtask

    task automatic send_beat(input lzfd_pkg::t_cmd cmd, input logic [7:0] b);
        if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
            while (stall_pct > 0 && $urandom_range(99) < stall_pct) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        predict(cmd, b);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cap(input logic [18:0] v);
        wait_drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= lzfd_pkg::REG_MAX_OUTPUT; pwdata <= 32'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cap = v;
    endtask

    task automatic flag_bytes(input logic [31:0] f);
        for (int k = 0; k < 4; k++) send_beat(lzfd_pkg::t_CMD_BYTE, f[8*k +: 8]);
    endtask

    // drain pending copy with ticks
    task automatic run_copy();
        while (remaining != 0 && !err) send_beat(lzfd_pkg::t_CMD_TICK, 8'($urandom));
    endtask

    task automatic send_match(input int off, input int len);
        logic [15:0] w;
        if (len <= 9) begin
            w = 16'(((off - 1) << 3) | (len - 3));
            send_beat(lzfd_pkg::t_CMD_BYTE, w[7:0]); send_beat(lzfd_pkg::t_CMD_BYTE, w[15:8]);
        end else begin
            w = 16'(((off - 1) << 3) | 7);
            send_beat(lzfd_pkg::t_CMD_BYTE, w[7:0]); send_beat(lzfd_pkg::t_CMD_BYTE, w[15:8]);
            if (len < 265) send_beat(lzfd_pkg::t_CMD_BYTE, 8'(len - 10));
            else begin
                send_beat(lzfd_pkg::t_CMD_BYTE, 8'hFF);
                if (len < 65536) begin
                    send_beat(lzfd_pkg::t_CMD_BYTE, 8'(len));
                    send_beat(lzfd_pkg::t_CMD_BYTE, 8'(len >> 8));
                end else begin
                    send_beat(lzfd_pkg::t_CMD_BYTE, 8'h00);
                    send_beat(lzfd_pkg::t_CMD_BYTE, 8'h00);
                    for (int k = 0; k < 4; k++)
                        send_beat(lzfd_pkg::t_CMD_BYTE, 8'(len >> (8 * k)));
                end
            end
        end
    endtask

    // one block with random tokens, some of them malformed; returns after the end beat
    task automatic random_block(input int groups);
        logic [31:0] f;
        int off, len, r;
        for (int g = 0; g < groups; g++) begin
            f = $urandom;
            flag_bytes(f);
            for (int t = 0; t < 32 && !err; t++) begin
                if (!f[t] || produced == 0) begin
                    if (f[t]) send_match(1, 3);
                    else send_beat(lzfd_pkg::t_CMD_BYTE, 8'($urandom));
                end else begin
                    off = $urandom_range(produced > 8191 ? 8191 : produced, 1);
                    if ($urandom_range(19) == 0) off = produced + 1;
                    r = $urandom_range(9);
                    len = r < 6 ? $urandom_range(9, 3) : r < 9 ? $urandom_range(40, 10)
                        : $urandom_range(300, 262);
                    send_match(off, len);
                    if ($urandom_range(9) == 0) send_beat(lzfd_pkg::t_CMD_BYTE, 8'($urandom));
                    if ($urandom_range(9) == 0) send_beat(lzfd_pkg::t_CMD_END, 8'($urandom));
                    run_copy();
                end
                if ($urandom_range(29) == 0) send_beat(lzfd_pkg::t_CMD_NOP, 8'($urandom));
            end
            if (err) send_beat(lzfd_pkg::t_CMD_BYTE, 8'($urandom));
        end
        send_beat(lzfd_pkg::t_CMD_END, 8'($urandom));
    endtask

    task automatic test_directed();
        flag_bytes(32'h0000_0006);
        send_beat(lzfd_pkg::t_CMD_BYTE, 8'h00);
        send_match(1, 3);
        send_beat(lzfd_pkg::t_CMD_END, 8'h00);
        run_copy();
        send_match(2, 10);
        run_copy();
        send_beat(lzfd_pkg::t_CMD_TICK, 8'hFF);
        send_beat(lzfd_pkg::t_CMD_NOP, 8'hA5);
        send_beat(lzfd_pkg::t_CMD_BYTE, 8'hFF);
        send_beat(lzfd_pkg::t_CMD_END, 8'h00);
        send_beat(lzfd_pkg::t_CMD_BYTE, 8'h12);
        send_beat(lzfd_pkg::t_CMD_END, 8'h00);
        flag_bytes(32'h0000_0001);
        send_match(9, 3);
        send_beat(lzfd_pkg::t_CMD_TICK, 8'h00);
        send_beat(lzfd_pkg::t_CMD_END, 8'h00);
    endtask

    // full rate on both sides for the whole of this test
    task automatic test_long_lengths();
        stall_pct = 0;
        flag_bytes(32'hFFFF_FFFE);
        send_beat(lzfd_pkg::t_CMD_BYTE, 8'h5A);
        send_match(1, 264);
        run_copy();
        send_match(1, 65535);
        repeat (20) send_beat(lzfd_pkg::t_CMD_TICK, 8'h00);
        send_beat(lzfd_pkg::t_CMD_END, 8'h00);
        stall_pct = 28;
    endtask

    task automatic test_limits();
        write_cap(19'd0);
        flag_bytes(32'h0);
        send_beat(lzfd_pkg::t_CMD_BYTE, 8'h11);
        send_beat(lzfd_pkg::t_CMD_END, 8'h00);
        write_cap(19'd6);
        flag_bytes(32'h0000_0002);
        send_beat(lzfd_pkg::t_CMD_BYTE, 8'h77);
        send_match(1, 300);
        run_copy();
        send_beat(lzfd_pkg::t_CMD_TICK, 8'h00);
        send_beat(lzfd_pkg::t_CMD_BYTE, 8'h00);
        send_beat(lzfd_pkg::t_CMD_END, 8'h00);
        // large 32-bit length, cut by cap
        write_cap(19'd40);
        flag_bytes(32'h0000_0002);
        send_beat(lzfd_pkg::t_CMD_BYTE, 8'hC3);
        send_match(1, 70000);
        run_copy();
        send_beat(lzfd_pkg::t_CMD_END, 8'h00);
        write_cap(19'h7FFFF);
        flag_bytes(32'h0000_0000);
        send_beat(lzfd_pkg::t_CMD_END, 8'h00);
    endtask

    task automatic test_random();
        int start;
        start = sent;
        write_cap(19'd40);
        random_block(1);
        while (sent - start < 150) begin
            write_cap(19'($urandom_range(80, 20)));
            random_block(1);
            if ($urandom_range(3) == 0) begin
                wait_drain();
                stall_pct = (stall_pct == 0) ? 28 : 0;
            end
        end
        stall_pct = 28;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_beat got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[29:11], lzfd_pkg::t_status'(m_axis_tdata[10:9]), m_axis_tlast,
                   m_axis_tdata[8], m_axis_tuser[0], m_axis_tdata[7:0]};
            if (pending_beats.size() == 0) begin
                $display("%0t unexpected beat: actual %h", $time, got);
                failures++;
            end else begin
                want = pending_beats.pop_front();
                if (got !== want) begin
                    $display("%0t beat: expected %h actual %h", $time, want, got);
                    failures++;
                end
            end
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);

    initial begin
        #200_000_000;
        $display("lz77_flag_word_decompressor_core: mismatch");
        $finish;
    end

    initial begin
        cap = lzfd_pkg::MAX_BLOCK;
        clear_block();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_long_lengths();
        test_limits();
        test_random();
        wait_drain();
        repeat (20) @(negedge i_clk);
        if (failures == 0 && pending_beats.size() == 0)
            $display("lz77_flag_word_decompressor_core: match");
        else
            $display("lz77_flag_word_decompressor_core: mismatch");
        $finish;
    end
endmodule

// ===== files.f =====
sv/lzfd_pkg.sv
sv/lz77_flag_word_decompressor_core.sv
dv/lz77_flag_word_decompressor_core_test.sv
